/* rtl/lwe_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lwe_pkg;

   localparam int unsigned CsrIndexWidth = 3;
   localparam int unsigned CsrDataWidth  = 24;

   // Configuration register indexes.
   localparam logic [CsrIndexWidth-1:0] CSR_CHECK_INTERVAL    = 3'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_STRENGTH_INTERVAL = 3'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_REASSOCIATE_AFTER = 3'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_LINK_REBOOT_AFTER = 3'd3;
   localparam logic [CsrIndexWidth-1:0] CSR_CLOUD_RETRY_AFTER = 3'd4;
   localparam logic [CsrIndexWidth-1:0] CSR_PROBE_AFTER       = 3'd5;
   localparam logic [CsrIndexWidth-1:0] CSR_QUIET_RESET_AFTER = 3'd6;

   // Reset values of the configuration registers.
   localparam logic [23:0] CHECK_INTERVAL_RESET    = 24'd10000;
   localparam logic [23:0] STRENGTH_INTERVAL_RESET = 24'd30000;
   localparam logic [15:0] REASSOCIATE_RESET       = 16'd60;
   localparam logic [15:0] LINK_REBOOT_RESET       = 16'd180;
   localparam logic [15:0] CLOUD_RETRY_RESET       = 16'd600;
   localparam logic [15:0] PROBE_RESET             = 16'd300;
   localparam logic [15:0] QUIET_RESET_RESET       = 16'd900;

   // Millisecond thresholds: (65535 + 1) * 1000 still fits in 26 bits.
   localparam int unsigned ThrWidth = 26;
   localparam logic [ThrWidth-1:0] MS_PER_S = 26'd1000;

   // floor(x / 1000) for any 32-bit x is (x * RECIP_1000) >> RecipShift.
   localparam logic [31:0] RECIP_1000  = 32'h10624DD3;
   localparam int unsigned RecipShift  = 38;
   localparam int unsigned SecWidth    = 23;

   typedef struct packed {
      logic [31:0]       now_ms;
      logic              link_ready;
      logic              cloud_connected;
      logic              traffic_seen;
      logic signed [7:0] strength_dbm;
   } req_type;

   typedef struct packed {
      logic              request_reset;
      logic              request_probe;
      logic              request_reassociate;
      logic              request_cloud_retry;
      logic [22:0]       link_down_seconds;
      logic [22:0]       quiet_seconds;
      logic [31:0]       recovery_count;
      logic signed [7:0] held_strength_dbm;
   } rsp_type;

   // Configuration as the decision logic uses it: second limits are kept
   // already scaled to milliseconds, so that floor(d / 1000) > L becomes
   // d >= (L + 1) * 1000 and the spacing checks compare against L * 1000.
   typedef struct packed {
      logic [23:0]         check_period_ms;
      logic [23:0]         strength_interval_ms;
      logic [ThrWidth-1:0] reassoc_down_ms;
      logic [ThrWidth-1:0] reassoc_space_ms;
      logic [ThrWidth-1:0] reboot_ms;
      logic [ThrWidth-1:0] cloud_retry_ms;
      logic [ThrWidth-1:0] probe_quiet_ms;
      logic [ThrWidth-1:0] probe_space_ms;
      logic [ThrWidth-1:0] quiet_reset_ms;
   } cfg_type;

   // Result of the decision stage, before the conversion to seconds.
   typedef struct packed {
      logic              request_reset;
      logic              request_probe;
      logic              request_reassociate;
      logic              request_cloud_retry;
      logic [31:0]       link_down_ms;
      logic [31:0]       quiet_ms;
      logic [31:0]       recovery_count;
      logic signed [7:0] held_strength_dbm;
   } decision_type;

   function automatic logic [ThrWidth-1:0] secs_to_ms(input logic [16:0] secs);
      logic [ThrWidth-1:0] ms;
      ms = {{(ThrWidth-17){1'b0}}, secs} * MS_PER_S;
      return ms;
   endfunction

endpackage

`default_nettype wire

/* rtl/lwe_csr.sv */
`timescale 1ns / 1ps
`default_nettype none

module lwe_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lwe_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [lwe_pkg::CsrDataWidth-1:0]   csr_data,
   output lwe_pkg::cfg_type                        cfg
);

   lwe_pkg::cfg_type cfg_ff;
   logic [16:0]      secs;
   logic [16:0]      secs_plus;

   assign csr_ready = 1'b1;
   assign secs      = {1'b0, csr_data[15:0]};
   assign secs_plus = secs + 17'd1;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.check_period_ms      <= lwe_pkg::CHECK_INTERVAL_RESET;
         cfg_ff.strength_interval_ms <= lwe_pkg::STRENGTH_INTERVAL_RESET;
         cfg_ff.reassoc_down_ms  <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::REASSOCIATE_RESET} + 17'd1);
         cfg_ff.reassoc_space_ms <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::REASSOCIATE_RESET});
         cfg_ff.reboot_ms        <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::LINK_REBOOT_RESET} + 17'd1);
         cfg_ff.cloud_retry_ms   <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::CLOUD_RETRY_RESET} + 17'd1);
         cfg_ff.probe_quiet_ms   <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::PROBE_RESET} + 17'd1);
         cfg_ff.probe_space_ms   <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::PROBE_RESET});
         cfg_ff.quiet_reset_ms   <= lwe_pkg::secs_to_ms({1'b0, lwe_pkg::QUIET_RESET_RESET} + 17'd1);
      end else if (csr_valid) begin
         unique case (csr_index)
            lwe_pkg::CSR_CHECK_INTERVAL: begin
               cfg_ff.check_period_ms <= csr_data;
            end
            lwe_pkg::CSR_STRENGTH_INTERVAL: begin
               cfg_ff.strength_interval_ms <= csr_data;
            end
            lwe_pkg::CSR_REASSOCIATE_AFTER: begin
               cfg_ff.reassoc_down_ms  <= lwe_pkg::secs_to_ms(secs_plus);
               cfg_ff.reassoc_space_ms <= lwe_pkg::secs_to_ms(secs);
            end
            lwe_pkg::CSR_LINK_REBOOT_AFTER: begin
               cfg_ff.reboot_ms <= lwe_pkg::secs_to_ms(secs_plus);
            end
            lwe_pkg::CSR_CLOUD_RETRY_AFTER: begin
               cfg_ff.cloud_retry_ms <= lwe_pkg::secs_to_ms(secs_plus);
            end
            lwe_pkg::CSR_PROBE_AFTER: begin
               cfg_ff.probe_quiet_ms <= lwe_pkg::secs_to_ms(secs_plus);
               cfg_ff.probe_space_ms <= lwe_pkg::secs_to_ms(secs);
            end
            lwe_pkg::CSR_QUIET_RESET_AFTER: begin
               cfg_ff.quiet_reset_ms <= lwe_pkg::secs_to_ms(secs_plus);
            end
            default: begin
            end
         endcase
      end
   end

endmodule

`default_nettype wire

/* rtl/lwe_decide.sv */
`timescale 1ns / 1ps
`default_nettype none

module lwe_decide (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  item_valid,
   input  wire lwe_pkg::req_type      item,
   input  wire lwe_pkg::cfg_type      cfg,
   output lwe_pkg::decision_type      decision
);

   logic [31:0]       last_check_ff, last_check_in;
   logic [31:0]       link_start_ff, link_start_in;
   logic              link_active_ff, link_active_in;
   logic [31:0]       cloud_start_ff, cloud_start_in;
   logic              cloud_active_ff, cloud_active_in;
   logic [31:0]       last_reassoc_ff, last_reassoc_in;
   logic [31:0]       last_strength_ff, last_strength_in;
   logic [31:0]       last_alive_ff, last_alive_in;
   logic [31:0]       last_probe_ff, last_probe_in;
   logic signed [7:0] strength_ff, strength_in;
   logic [31:0]       recoveries_ff, recoveries_in;

   lwe_pkg::decision_type decision_ff, decision_in;

   logic        update;
   logic [31:0] now;
   logic [31:0] alive_traffic;
   logic [31:0] quiet_ms;
   logic [31:0] down_ms;
   logic [31:0] cloud_down_ms;
   logic [31:0] link_start_sel;
   logic [31:0] cloud_start_sel;

   assign update = advance & item_valid;
   assign now    = item.now_ms;

   always_comb begin
      last_check_in    = last_check_ff;
      link_start_in    = link_start_ff;
      link_active_in   = link_active_ff;
      cloud_start_in   = cloud_start_ff;
      cloud_active_in  = cloud_active_ff;
      last_reassoc_in  = last_reassoc_ff;
      last_strength_in = last_strength_ff;
      last_probe_in    = last_probe_ff;
      strength_in      = strength_ff;
      recoveries_in    = recoveries_ff;

      decision_in.request_reset       = 1'b0;
      decision_in.request_probe       = 1'b0;
      decision_in.request_reassociate = 1'b0;
      decision_in.request_cloud_retry = 1'b0;

      // Traffic counts as proof of life before anything else looks at it.
      alive_traffic = item.traffic_seen ? now : last_alive_ff;
      last_alive_in = alive_traffic;

      if (((now - last_strength_ff) >= {8'd0, cfg.strength_interval_ms}) && item.link_ready) begin
         last_strength_in = now;
         strength_in      = item.strength_dbm;
      end

      link_start_sel  = link_active_ff ? link_start_ff : now;
      cloud_start_sel = cloud_active_ff ? cloud_start_ff : now;
      quiet_ms        = now - (item.cloud_connected ? now : alive_traffic);
      down_ms         = now - link_start_sel;
      cloud_down_ms   = now - cloud_start_sel;

      if ((now - last_check_ff) >= {8'd0, cfg.check_period_ms}) begin
         last_check_in = now;
         if (item.link_ready) begin
            link_active_in = 1'b0;
            if (item.cloud_connected) begin
               last_alive_in = now;
            end
            if (quiet_ms >= 32'(cfg.quiet_reset_ms)) begin
               decision_in.request_reset = 1'b1;
            end else if ((quiet_ms >= 32'(cfg.probe_quiet_ms)) &&
                         ((now - last_probe_ff) > 32'(cfg.probe_space_ms))) begin
               last_probe_in             = now;
               decision_in.request_probe = 1'b1;
            end
            if (!decision_in.request_reset) begin
               if (item.cloud_connected) begin
                  cloud_active_in = 1'b0;
               end else begin
                  cloud_active_in = 1'b1;
                  cloud_start_in  = cloud_start_sel;
                  if (cloud_down_ms >= 32'(cfg.cloud_retry_ms)) begin
                     cloud_start_in                  = now;
                     decision_in.request_cloud_retry = 1'b1;
                  end
               end
            end
         end else begin
            link_active_in = 1'b1;
            link_start_in  = link_start_sel;
            if (down_ms >= 32'(cfg.reboot_ms)) begin
               decision_in.request_reset = 1'b1;
            end else if ((down_ms >= 32'(cfg.reassoc_down_ms)) &&
                         ((now - last_reassoc_ff) > 32'(cfg.reassoc_space_ms))) begin
               last_reassoc_in                 = now;
               recoveries_in                   = recoveries_ff + 32'd1;
               decision_in.request_reassociate = 1'b1;
            end
         end
      end

      decision_in.link_down_ms      = link_active_in ? (now - link_start_in) : 32'd0;
      decision_in.quiet_ms          = now - last_alive_in;
      decision_in.recovery_count    = recoveries_in;
      decision_in.held_strength_dbm = strength_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_check_ff    <= 32'd0;
         link_start_ff    <= 32'd0;
         link_active_ff   <= 1'b1;
         cloud_start_ff   <= 32'd0;
         cloud_active_ff  <= 1'b1;
         last_reassoc_ff  <= 32'd0;
         last_strength_ff <= 32'd0;
         last_alive_ff    <= 32'd0;
         last_probe_ff    <= 32'd0;
         strength_ff      <= 8'sd0;
         recoveries_ff    <= 32'd0;
      end else if (update) begin
         last_check_ff    <= last_check_in;
         link_start_ff    <= link_start_in;
         link_active_ff   <= link_active_in;
         cloud_start_ff   <= cloud_start_in;
         cloud_active_ff  <= cloud_active_in;
         last_reassoc_ff  <= last_reassoc_in;
         last_strength_ff <= last_strength_in;
         last_alive_ff    <= last_alive_in;
         last_probe_ff    <= last_probe_in;
         strength_ff      <= strength_in;
         recoveries_ff    <= recoveries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         decision_ff <= decision_in;
      end
   end

   assign decision = decision_ff;

   // A reassociation always bumps the recovery count by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      update && decision_in.request_reassociate |=> recoveries_ff == $past(recoveries_ff) + 32'd1)
      else $error("recovery count did not follow a reassociation");

   // The count never moves without a reassociation.
   assert property (@(posedge clock) disable iff (reset)
      !(update && decision_in.request_reassociate) |=> $stable(recoveries_ff))
      else $error("recovery count moved without a reassociation");

   // A link that is up never leaves a nonzero down time behind.
   assert property (@(posedge clock) disable iff (reset)
      update && !link_active_in |-> decision_in.link_down_ms == 32'd0)
      else $error("link down time reported while the link is up");

endmodule

`default_nettype wire

/* rtl/lwe_seconds.sv */
`timescale 1ns / 1ps
`default_nettype none

module lwe_seconds (
   input  wire logic                  clock,
   input  wire logic                  advance,
   input  wire lwe_pkg::decision_type decision,
   output lwe_pkg::rsp_type           result
);

   lwe_pkg::rsp_type result_ff, result_in;
   logic [63:0]      link_prod;
   logic [63:0]      quiet_prod;

   // Division by 1000 as a multiply by the scaled reciprocal, exact over 32 bits.
   assign link_prod  = {32'd0, decision.link_down_ms} * {32'd0, lwe_pkg::RECIP_1000};
   assign quiet_prod = {32'd0, decision.quiet_ms} * {32'd0, lwe_pkg::RECIP_1000};

   always_comb begin
      result_in.request_reset       = decision.request_reset;
      result_in.request_probe       = decision.request_probe;
      result_in.request_reassociate = decision.request_reassociate;
      result_in.request_cloud_retry = decision.request_cloud_retry;
      result_in.link_down_seconds   =
         link_prod[lwe_pkg::RecipShift +: lwe_pkg::SecWidth];
      result_in.quiet_seconds       =
         quiet_prod[lwe_pkg::RecipShift +: lwe_pkg::SecWidth];
      result_in.recovery_count      = decision.recovery_count;
      result_in.held_strength_dbm   = decision.held_strength_dbm;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire

/* rtl/link_watchdog_escalation.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                                      Direction  Item
// request   req_valid, req_ready, req_item             in         one tick (lwe_pkg::req_type)
// response  rsp_valid, rsp_ready, rsp_item             out        one result per tick
// config    csr_valid, csr_ready, csr_index, csr_data  in         one register write
//
// One tick is accepted every cycle while the response side keeps up; each tick
// passes three registers (input, decision, seconds) in that order, the first
// loading at the accepting edge; its result is offered from the seconds register.
// The decision stage holds all watchdog state and updates it once per tick.
// Synchronous reset restores the register defaults and the watchdog state. A
// stall on rsp_ready freezes all three stages at once, so req_ready drops
// whenever a result waits on a low rsp_ready, even with bubbles in the pipe.

module link_watchdog_escalation (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire lwe_pkg::req_type                   req_item,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output lwe_pkg::rsp_type                        rsp_item,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [lwe_pkg::CsrIndexWidth-1:0]  csr_index,
   input  wire logic [lwe_pkg::CsrDataWidth-1:0]   csr_data
);

   lwe_pkg::cfg_type      cfg;
   lwe_pkg::decision_type decision;
   lwe_pkg::req_type      in_item_ff;

   logic in_valid_ff;
   logic dec_valid_ff;
   logic rsp_valid_ff;
   logic advance;

   // The whole pipe moves whenever the output slot is empty or being taken.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         dec_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         in_valid_ff  <= req_valid;
         dec_valid_ff <= in_valid_ff;
         rsp_valid_ff <= dec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_item_ff <= req_item;
      end
   end

   lwe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   lwe_decide u_decide (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .item_valid (in_valid_ff),
      .item       (in_item_ff),
      .cfg        (cfg),
      .decision   (decision)
   );

   lwe_seconds u_seconds (
      .clock    (clock),
      .advance  (advance),
      .decision (decision),
      .result   (rsp_item)
   );

   // A reset request suppresses every other action of the same tick.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.request_reset |->
         !rsp_item.request_probe && !rsp_item.request_reassociate &&
         !rsp_item.request_cloud_retry)
      else $error("reset request came with another action");

   // Probes happen with the link up, reassociations with it down.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_item.request_probe && rsp_item.request_reassociate))
      else $error("probe and reassociation on the same tick");

   // A stalled pipe keeps the tick waiting in the input register.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("input stage lost a tick during a stall");

endmodule

`default_nettype wire

/* tb/tb_link_watchdog_escalation.sv */
`timescale 1ns / 1ps

module tb_link_watchdog_escalation;
   import lwe_pkg::*;

   // The upper bound of the run. A correct run with the heaviest idling stays
   // well below a tenth of this.
   localparam int unsigned TimeoutNs = 2_000_000;
   localparam logic [31:0] MsPerSec  = 32'd1000;

   // An index past the end of the register list; writes to it must be ignored.
   localparam logic [CsrIndexWidth-1:0] CsrUnmapped = 3'd7;

   // The order in which a full register set is written.
   localparam logic [CsrIndexWidth-1:0] RegOrder [7] = '{
      CSR_CHECK_INTERVAL, CSR_STRENGTH_INTERVAL, CSR_REASSOCIATE_AFTER,
      CSR_LINK_REBOOT_AFTER, CSR_CLOUD_RETRY_AFTER, CSR_PROBE_AFTER,
      CSR_QUIET_RESET_AFTER
   };

   // A full register set; entry i goes to RegOrder[i].
   typedef logic [6:0][CsrDataWidth-1:0] reg_set_type;

   // One row of the directed table: the tick, whether the result is typed in,
   // and the typed result.
   typedef struct packed {
      req_type tick;
      logic    typed;
      rsp_type want;
   } tick_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_item  = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_item;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data  = '0;

   link_watchdog_escalation u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog configuration as the predictor sees it, widened to 32 bits so
   // that every compare below works on plain 32-bit unsigned values.
   logic [31:0] cfg_check, cfg_strength, cfg_reassoc, cfg_reboot;
   logic [31:0] cfg_cloud, cfg_probe, cfg_quiet;

   // Watchdog state of the predictor.
   logic [31:0]       chk_time, down_start, cloud_start, reassoc_time;
   logic [31:0]       strength_time, alive_time, probe_time, recov_cnt;
   logic              down_active, cloud_active;
   logic signed [7:0] strength_reg;

   // Results still owed by the block, oldest first.
   rsp_type pending_results [$];
   int      mismatches = 0;

   // What the sender is currently offering besides the payload: for typed rows
   // the result to expect is the one from the table, not from the predictor.
   logic    tick_typed = 1'b0;
   rsp_type tick_want  = '0;

   // Random idling, in percent of cycles.
   int idle_pct  = 0;
   int stall_pct = 0;

   // Free-running state of the random tick generator.
   logic [31:0] gen_now   = 32'd0;
   logic        gen_link  = 1'b0;
   logic        gen_cloud = 1'b0;

   tick_row_type dir_rows [15];

   function automatic void restore_defaults();
      cfg_check     = {8'd0, CHECK_INTERVAL_RESET};
      cfg_strength  = {8'd0, STRENGTH_INTERVAL_RESET};
      cfg_reassoc   = {16'd0, REASSOCIATE_RESET};
      cfg_reboot    = {16'd0, LINK_REBOOT_RESET};
      cfg_cloud     = {16'd0, CLOUD_RETRY_RESET};
      cfg_probe     = {16'd0, PROBE_RESET};
      cfg_quiet     = {16'd0, QUIET_RESET_RESET};
      chk_time      = '0;
      down_start    = '0;
      down_active   = 1'b1;
      cloud_start   = '0;
      cloud_active  = 1'b1;
      reassoc_time  = '0;
      strength_time = '0;
      alive_time    = '0;
      probe_time    = '0;
      strength_reg  = '0;
      recov_cnt     = '0;
   endfunction

   // A register write as the block applies it: the 16-bit limits keep only
   // the low half of the data word.
   function automatic void apply_reg(logic [CsrIndexWidth-1:0] idx,
                                     logic [CsrDataWidth-1:0] data);
      case (idx)
         CSR_CHECK_INTERVAL:    cfg_check    = {8'd0, data};
         CSR_STRENGTH_INTERVAL: cfg_strength = {8'd0, data};
         CSR_REASSOCIATE_AFTER: cfg_reassoc  = {16'd0, data[15:0]};
         CSR_LINK_REBOOT_AFTER: cfg_reboot   = {16'd0, data[15:0]};
         CSR_CLOUD_RETRY_AFTER: cfg_cloud    = {16'd0, data[15:0]};
         CSR_PROBE_AFTER:       cfg_probe    = {16'd0, data[15:0]};
         CSR_QUIET_RESET_AFTER: cfg_quiet    = {16'd0, data[15:0]};
         default: ;
      endcase
   endfunction

   // Advances the predicted watchdog by one tick and returns its result.
   function automatic rsp_type watchdog_tick(req_type t);
      rsp_type     r;
      logic [31:0] now, quiet, down, down_s, quiet_s;
      r   = '0;
      now = t.now_ms;

      // Proof of life is applied before anything else looks at the time.
      if (t.traffic_seen)
         alive_time = now;

      // Strength is only captured while the link is up.
      if ((now - strength_time) >= cfg_strength && t.link_ready) begin
         strength_time = now;
         strength_reg  = t.strength_dbm;
      end

      if ((now - chk_time) >= cfg_check) begin
         chk_time = now;
         if (t.link_ready) begin
            down_active = 1'b0;
            if (t.cloud_connected)
               alive_time = now;
            quiet = (now - alive_time) / MsPerSec;
            if (quiet > cfg_quiet) begin
               r.request_reset = 1'b1;
            end else if (quiet > cfg_probe && (now - probe_time) > cfg_probe * MsPerSec) begin
               probe_time      = now;
               r.request_probe = 1'b1;
            end
            // A reset request holds back the cloud check entirely.
            if (!r.request_reset) begin
               if (t.cloud_connected) begin
                  cloud_active = 1'b0;
               end else begin
                  if (!cloud_active) begin
                     cloud_active = 1'b1;
                     cloud_start  = now;
                  end
                  if ((now - cloud_start) / MsPerSec > cfg_cloud) begin
                     cloud_start           = now;
                     r.request_cloud_retry = 1'b1;
                  end
               end
            end
         end else begin
            if (!down_active) begin
               down_active = 1'b1;
               down_start  = now;
            end
            down = (now - down_start) / MsPerSec;
            if (down > cfg_reboot) begin
               r.request_reset = 1'b1;
            end else if (down > cfg_reassoc &&
                         (now - reassoc_time) > cfg_reassoc * MsPerSec) begin
               reassoc_time          = now;
               recov_cnt             = recov_cnt + 32'd1;
               r.request_reassociate = 1'b1;
            end
         end
      end

      down_s  = down_active ? (now - down_start) / MsPerSec : 32'd0;
      quiet_s = (now - alive_time) / MsPerSec;
      r.link_down_seconds = down_s[22:0];
      r.quiet_seconds     = quiet_s[22:0];
      r.recovery_count    = recov_cnt;
      r.held_strength_dbm = strength_reg;
      return r;
   endfunction

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   function automatic req_type mk_tick(logic [31:0] now, logic link, logic cloud,
                                       logic traffic, logic signed [7:0] strength);
      req_type t;
      t.now_ms          = now;
      t.link_ready      = link;
      t.cloud_connected = cloud;
      t.traffic_seen    = traffic;
      t.strength_dbm    = strength;
      return t;
   endfunction

   function automatic rsp_type mk_rsp(logic rst, logic probe, logic reassoc, logic cloud,
                                      logic [22:0] down_s, logic [22:0] quiet_s,
                                      logic [31:0] recov, logic signed [7:0] held);
      rsp_type r;
      r.request_reset       = rst;
      r.request_probe       = probe;
      r.request_reassociate = reassoc;
      r.request_cloud_retry = cloud;
      r.link_down_seconds   = down_s;
      r.quiet_seconds       = quiet_s;
      r.recovery_count      = recov;
      r.held_strength_dbm   = held;
      return r;
   endfunction

   function automatic reg_set_type regs_of(logic [23:0] c0, logic [23:0] c1,
                                           logic [23:0] c2, logic [23:0] c3,
                                           logic [23:0] c4, logic [23:0] c5,
                                           logic [23:0] c6);
      reg_set_type v;
      v[0] = c0; v[1] = c1; v[2] = c2; v[3] = c3;
      v[4] = c4; v[5] = c5; v[6] = c6;
      return v;
   endfunction

   // All handshakes are sampled here, at the rising edge, before the block's
   // own registers move. The result check runs first so that a result that
   // shows up too early never meets an expectation pushed on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result item with no tick outstanding");
               mismatches++;
            end else begin
               rsp_type want;
               want = pending_results.pop_front();
               check_field("request_reset", want.request_reset, rsp_item.request_reset);
               check_field("request_probe", want.request_probe, rsp_item.request_probe);
               check_field("request_reassociate", want.request_reassociate,
                           rsp_item.request_reassociate);
               check_field("request_cloud_retry", want.request_cloud_retry,
                           rsp_item.request_cloud_retry);
               check_field("link_down_seconds", want.link_down_seconds,
                           rsp_item.link_down_seconds);
               check_field("quiet_seconds", want.quiet_seconds, rsp_item.quiet_seconds);
               check_field("recovery_count", want.recovery_count, rsp_item.recovery_count);
               check_field("held_strength_dbm", want.held_strength_dbm,
                           rsp_item.held_strength_dbm);
            end
         end
         if (csr_valid && csr_ready)
            apply_reg(csr_index, csr_data);
         if (req_valid && req_ready) begin
            rsp_type predicted;
            // The predictor always runs so its state follows the block; a typed
            // row only replaces what is expected for this one item.
            predicted = watchdog_tick(req_item);
            pending_results.push_back(tick_typed ? tick_want : predicted);
         end
      end
   end

   // The receiver stalls at random; the rate is set per phase.
   always @(negedge clock)
      rsp_ready <= !reset && ($urandom_range(0, 99) >= stall_pct);

   // Offers one tick, with random idle cycles in front of it, and returns at
   // the falling edge after it was taken. Valid stays high on return so that
   // back-to-back items never see it drop.
   task automatic send_tick(req_type tick, logic typed, rsp_type want);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_item   = tick;
      tick_typed = typed;
      tick_want  = want;
      req_valid  = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [CsrIndexWidth-1:0] idx, logic [CsrDataWidth-1:0] data);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // One phase of random ticks. The block is drained first so that new
   // register values never meet a tick in flight. Time mostly moves forward in
   // steps of up to span ms; now and then it jumps anywhere or steps back, which
   // exercises the modulo 2^32 differences. Link and cloud flip rarely, so long
   // outages and long quiet stretches build up and reach the escalation limits.
   task automatic run_phase(reg_set_type regs, logic do_write, int unsigned span,
                            int send_idle, int recv_stall, int count);
      int unsigned      sel;
      logic signed [7:0] strength;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (5) @(negedge clock);
      if (do_write) begin
         for (int i = 0; i < 7; i++)
            write_reg(RegOrder[i], regs[i]);
         write_reg(CsrUnmapped, 24'($urandom));
         csr_valid = 1'b0;
      end
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3)
            gen_now = $urandom;
         else if (sel < 6)
            gen_now = gen_now - $urandom_range(0, span);
         else
            gen_now = gen_now + $urandom_range(0, span);
         if ($urandom_range(0, 99) < 4)
            gen_link = !gen_link;
         if ($urandom_range(0, 99) < 5)
            gen_cloud = !gen_cloud;
         // Mostly legal dBm values; sometimes any byte, which is held as given.
         if ($urandom_range(0, 9) == 0)
            strength = 8'($urandom);
         else
            strength = 8'(0 - $urandom_range(0, 128));
         send_tick(mk_tick(gen_now, gen_link, gen_cloud, $urandom_range(0, 99) < 5, strength),
                   1'b0, '0);
      end
      req_valid = 1'b0;
   endtask

   initial begin
      #(TimeoutNs);
      $display("tb_link_watchdog_escalation: FAIL");
      $finish;
   end

   initial begin
      logic [23:0] chk;
      restore_defaults();

      // Directed ticks under the reset configuration. The first rows walk a
      // link outage from power up through a reassociation to a reset request,
      // then the link comes up between checks. Later rows drive quiet time
      // into a probe, a probe together with a cloud retry and a quiet reset;
      // then a strength byte above zero, traffic while the link is down
      // between checks, and a jump across the 2^32 wrap.
      dir_rows[0]  = {mk_tick(32'd0, 1'b0, 1'b0, 1'b0, 8'sd0), 1'b1,
                      mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 23'd0, 23'd0, 32'd0, 8'sd0)};
      dir_rows[1]  = {mk_tick(32'd10000, 1'b0, 1'b0, 1'b0, -8'sd5), 1'b1,
                      mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 23'd10, 23'd10, 32'd0, 8'sd0)};
      dir_rows[2]  = {mk_tick(32'd61000, 1'b0, 1'b0, 1'b0, 8'sd0), 1'b1,
                      mk_rsp(1'b0, 1'b0, 1'b1, 1'b0, 23'd61, 23'd61, 32'd1, 8'sd0)};
      dir_rows[3]  = {mk_tick(32'd181000, 1'b0, 1'b0, 1'b0, 8'sd0), 1'b1,
                      mk_rsp(1'b1, 1'b0, 1'b0, 1'b0, 23'd181, 23'd181, 32'd1, 8'sd0)};
      dir_rows[4]  = {mk_tick(32'd190000, 1'b1, 1'b1, 1'b1, 8'sh80), 1'b1,
                      mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 23'd190, 23'd0, 32'd1, 8'sh80)};
      dir_rows[5]  = {mk_tick(32'd191000, 1'b1, 1'b1, 1'b0, -8'sd60), 1'b1,
                      mk_rsp(1'b0, 1'b0, 1'b0, 1'b0, 23'd0, 23'd0, 32'd1, 8'sh80)};
      dir_rows[6]  = {mk_tick(32'd221000, 1'b1, 1'b0, 1'b0, 8'sd0), 1'b0, rsp_type'(0)};
      dir_rows[7]  = {mk_tick(32'd522000, 1'b1, 1'b0, 1'b0, -8'sd40), 1'b0, rsp_type'(0)};
      dir_rows[8]  = {mk_tick(32'd832000, 1'b1, 1'b0, 1'b0, -8'sd90), 1'b0, rsp_type'(0)};
      dir_rows[9]  = {mk_tick(32'd1100000, 1'b1, 1'b0, 1'b0, -8'sd1), 1'b0, rsp_type'(0)};
      dir_rows[10] = {mk_tick(32'd1131000, 1'b1, 1'b1, 1'b0, 8'sd127), 1'b0, rsp_type'(0)};
      dir_rows[11] = {mk_tick(32'd1135000, 1'b0, 1'b1, 1'b1, -8'sd20), 1'b0, rsp_type'(0)};
      dir_rows[12] = {mk_tick(32'hFFFF_F000, 1'b0, 1'b0, 1'b0, 8'sh80), 1'b0, rsp_type'(0)};
      dir_rows[13] = {mk_tick(32'h0000_E000, 1'b0, 1'b0, 1'b0, 8'sh80), 1'b0, rsp_type'(0)};
      dir_rows[14] = {mk_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 8'sd0), 1'b0, rsp_type'(0)};

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < 15; i++)
         send_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].want);
      req_valid = 1'b0;
      gen_now   = dir_rows[14].tick.now_ms;

      // Reset configuration, no idling on either side.
      run_phase('0, 1'b0, 20000, 0, 0, 150);

      // Short limits, so outages, probes, retries and quiet resets come often.
      // The 16-bit registers get junk in their upper data bits.
      run_phase(regs_of(24'd1000, 24'd3000, {8'hA5, 16'd5}, {8'h5A, 16'd20},
                        {8'hFF, 16'd10}, {8'h81, 16'd3}, {8'h3C, 16'd15}),
                1'b1, 2000, 60, 0, 170);

      // Every register at zero: a check on every tick, any down or quiet
      // second escalates at once.
      run_phase('0, 1'b1, 3000, 0, 60, 120);

      // Every register at its largest value.
      run_phase(regs_of(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF,
                        24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF),
                1'b1, 40_000_000, 28, 28, 120);

      // A random small configuration.
      chk = 24'($urandom_range(0, 5000));
      run_phase(regs_of(chk, 24'($urandom_range(0, 20000)),
                        {8'($urandom), 16'($urandom_range(0, 30))},
                        {8'($urandom), 16'($urandom_range(0, 120))},
                        {8'($urandom), 16'($urandom_range(0, 60))},
                        {8'($urandom), 16'($urandom_range(0, 40))},
                        {8'($urandom), 16'($urandom_range(0, 150))}),
                1'b1, 2 * chk + 1000, 28, 28, 200);

      // Back to the reset values, written explicitly this time.
      run_phase(regs_of(CHECK_INTERVAL_RESET, STRENGTH_INTERVAL_RESET,
                        {8'd0, REASSOCIATE_RESET}, {8'd0, LINK_REBOOT_RESET},
                        {8'd0, CLOUD_RETRY_RESET}, {8'd0, PROBE_RESET},
                        {8'd0, QUIET_RESET_RESET}),
                1'b1, 20000, 0, 60, 170);

      // Let the last results drain, then give any stray extra result a chance
      // to show up before the verdict.
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("tb_link_watchdog_escalation: PASS");
      end else begin
         $display("tb_link_watchdog_escalation: FAIL");
      end
      $finish;
   end

endmodule
